// ===== hdl/audio_peak_vu_meter_unit_defines.svh =====
// Assertion macros used by the VU meter checker.
`ifndef AUDIO_PEAK_VU_METER_UNIT_DEFINES_SVH
`define AUDIO_PEAK_VU_METER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define APVU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define APVU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/apvu_pkg.sv =====
// Shared types, constants and the log2 mantissa table of the VU meter.
package apvu_pkg;

	localparam int LOG_BITS = 8;
	localparam int LOG_SIZE = 1 << LOG_BITS;

	localparam int PEAK_W  = 15;
	localparam int BAR_W   = 10;
	localparam int FLOOR_W = 8;
	localparam int COLOR_W = 16;
	localparam int EXP_W   = 4;
	localparam int L2_W    = 12;
	localparam int ATT_W   = 15;

	localparam logic [PEAK_W-1:0] FULL_SCALE = 15'd32767;
	localparam logic [14:0] DB_PER_OCTAVE_Q12 = 15'd24660;

	localparam logic [COLOR_W-1:0] COLOR_GREEN  = 16'hE007;
	localparam logic [COLOR_W-1:0] COLOR_YELLOW = 16'hE0FF;
	localparam logic [COLOR_W-1:0] COLOR_RED    = 16'h00F8;

	// register indexes on the configuration port (address bits 4:2)
	localparam logic [2:0] REG_CHANNEL_SELECT = 3'd0;
	localparam logic [2:0] REG_BAR_WIDTH      = 3'd1;
	localparam logic [2:0] REG_FLOOR_DB       = 3'd2;
	localparam logic [2:0] REG_YELLOW_THRESH  = 3'd3;
	localparam logic [2:0] REG_RED_THRESH     = 3'd4;

	localparam logic [BAR_W-1:0]   RST_BAR_WIDTH = 10'd128;
	localparam logic [FLOOR_W-1:0] RST_FLOOR_DB  = 8'hC4;
	localparam logic [PEAK_W-1:0]  RST_YELLOW    = 15'd16384;
	localparam logic [PEAK_W-1:0]  RST_RED       = 15'd29205;

	typedef struct packed {
		logic               channel_select;
		logic [BAR_W-1:0]   bar_width;
		logic [FLOOR_W-1:0] floor_db;
		logic [PEAK_W-1:0]  yellow_threshold;
		logic [PEAK_W-1:0]  red_threshold;
	} cfg_t;

	typedef logic [LOG_SIZE-1:0][7:0] log_tbl_t;

	// Fraction bits of log2(1 + m/2^LOG_BITS), produced one bit per squaring.
	function automatic log_tbl_t build_log_table();
		log_tbl_t    t;
		logic [63:0] x;
		logic [7:0]  r;
		for (int m = 0; m < LOG_SIZE; m++) begin
			x = 64'(LOG_SIZE + m) << (30 - LOG_BITS);
			r = '0;
			for (int i = 0; i < 8; i++) begin
				x = (x * x) >> 30;
				r = {r[6:0], 1'b0};
				if (x >= 64'h8000_0000) begin
					r[0] = 1'b1;
					x = x >> 1;
				end
			end
			t[m] = r;
		end
		return t;
	endfunction

	localparam log_tbl_t LOG_TABLE = build_log_table();

	localparam int FULL_IDX = ((32767 << LOG_BITS) >> 14) % LOG_SIZE;
	localparam logic [L2_W-1:0] REF_L2 = L2_W'(14 * 256 + int'(LOG_TABLE[FULL_IDX]));

endpackage

// ===== hdl/apvu_front.sv =====
// Front end: channel select, magnitude, running peak, window close.
module apvu_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  apvu_pkg::cfg_t               cfg,
	input  logic [31:0]                  frame_word,
	input  logic                         last_frame,
	input  logic                         push,
	output logic                         full,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [apvu_pkg::PEAK_W-1:0]  q_data
);

	logic [apvu_pkg::PEAK_W-1:0] peak_q;
	logic [15:0]                 half;
	logic [15:0]                 neg;
	logic [apvu_pkg::PEAK_W-1:0] mag;
	logic [apvu_pkg::PEAK_W-1:0] new_peak;
	logic                        beat;

	assign half = cfg.channel_select ? frame_word[15:0] : frame_word[31:16];
	assign neg  = ~half + 16'd1;

	always_comb begin
		if (!half[15])
			mag = half[14:0];
		else if (neg[15])
			mag = apvu_pkg::FULL_SCALE;  // saturate the most negative sample
		else
			mag = neg[14:0];
	end

	assign new_peak = (mag > peak_q) ? mag : peak_q;
	assign full     = q_full;
	assign beat     = push && !q_full;
	assign q_push   = beat && last_frame;
	assign q_data   = new_peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (beat) begin
			peak_q <= last_frame ? '0 : new_peak;
		end
	end

endmodule

// ===== hdl/apvu_fifo.sv =====
// Short queue of closed-window peaks between front and back end.
module apvu_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [apvu_pkg::PEAK_W-1:0]  wr_data,
	input  logic                         rd_en,
	output logic [apvu_pkg::PEAK_W-1:0]  rd_data,
	output logic                         full,
	output logic                         empty
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	logic [apvu_pkg::PEAK_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [PTR_W:0]              count_q;
	logic                        do_wr;
	logic                        do_rd;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/apvu_back.sv =====
// Back end: log2 scale, dB attenuation, bar length divider, color, result register.
module apvu_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  apvu_pkg::cfg_t                cfg,
	input  logic                          q_empty,
	input  logic [apvu_pkg::PEAK_W-1:0]   q_data,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [apvu_pkg::PEAK_W-1:0]   peak_level,
	output logic [apvu_pkg::BAR_W-1:0]    bar_pixels,
	output logic [apvu_pkg::COLOR_W-1:0]  bar_color
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_NORM  = 4'd1;
	localparam logic [3:0] ST_LOG   = 4'd2;
	localparam logic [3:0] ST_ATT   = 4'd3;
	localparam logic [3:0] ST_CLASS = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_DONE  = 4'd7;

	localparam int REM_W = 27;

	logic [3:0]                     state_q;
	logic [apvu_pkg::PEAK_W-1:0]    p_q;
	logic [apvu_pkg::EXP_W-1:0]     e_q;
	logic [apvu_pkg::LOG_BITS-1:0]  m_q;
	logic [apvu_pkg::COLOR_W-1:0]   color_q;
	logic [apvu_pkg::L2_W-1:0]      a_q;
	logic [apvu_pkg::ATT_W-1:0]     att_q;
	logic [15:0]                    span_q;
	logic [15:0]                    num_q;
	logic [REM_W-1:0]               rem_q;
	logic [apvu_pkg::BAR_W-1:0]     quo_q;
	logic [3:0]                     cnt_q;

	logic                           out_valid_q;
	logic [apvu_pkg::PEAK_W-1:0]    out_peak_q;
	logic [apvu_pkg::BAR_W-1:0]     out_bar_q;
	logic [apvu_pkg::COLOR_W-1:0]   out_color_q;

	logic [apvu_pkg::EXP_W-1:0]     lead;
	logic [apvu_pkg::PEAK_W+apvu_pkg::LOG_BITS-1:0] aligned;
	logic [apvu_pkg::L2_W-1:0]      l2;
	logic [26:0]                    att_prod;
	logic [15:0]                    floor_q88;
	logic signed [17:0]             margin;
	logic [25:0]                    mul_prod;
	logic [REM_W-1:0]               div_shift;
	logic                           out_free;

	// leading-one position of the peak
	always_comb begin
		lead = '0;
		for (int i = 1; i < apvu_pkg::PEAK_W; i++) begin
			if (p_q[i])
				lead = apvu_pkg::EXP_W'(i);
		end
	end

	assign aligned   = {p_q, {apvu_pkg::LOG_BITS{1'b0}}} >> lead;
	assign l2        = {e_q, 8'b0} + apvu_pkg::L2_W'(apvu_pkg::LOG_TABLE[m_q]);
	assign att_prod  = 27'(a_q) * 27'(apvu_pkg::DB_PER_OCTAVE_Q12) + 27'd2048;
	assign floor_q88 = {cfg.floor_db, 8'b0};
	assign margin    = $signed({3'b0, att_q}) + $signed({{2{floor_q88[15]}}, floor_q88});
	assign mul_prod  = 26'(num_q) * 26'(cfg.bar_width);
	assign div_shift = REM_W'({span_q, 1'b0}) << cnt_q;
	assign out_free  = !out_valid_q || pop;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (!q_empty) state_q <= ST_NORM;
				ST_NORM:  state_q <= ST_LOG;
				ST_LOG:   state_q <= ST_ATT;
				ST_ATT:   state_q <= ST_CLASS;
				ST_CLASS: begin
					priority if (p_q == '0 || margin >= 0 || att_q == '0)
						state_q <= ST_DONE;
					else
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
					cnt_q   <= 4'(apvu_pkg::BAR_W - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_DONE:  if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty)
					p_q <= q_data;
			end
			ST_NORM: begin
				e_q <= lead;
				m_q <= aligned[apvu_pkg::LOG_BITS-1:0];
				if (p_q < cfg.yellow_threshold)
					color_q <= apvu_pkg::COLOR_GREEN;
				else if (p_q < cfg.red_threshold)
					color_q <= apvu_pkg::COLOR_YELLOW;
				else
					color_q <= apvu_pkg::COLOR_RED;
			end
			ST_LOG: begin
				a_q <= (apvu_pkg::REF_L2 > l2) ? (apvu_pkg::REF_L2 - l2) : '0;
			end
			ST_ATT: begin
				att_q <= att_prod[12 +: apvu_pkg::ATT_W];
			end
			ST_CLASS: begin
				priority if (p_q == '0 || margin >= 0)
					quo_q <= '0;
				else if (att_q == '0)
					quo_q <= cfg.bar_width;
				else
					quo_q <= '0;
				span_q <= 16'(-{floor_q88[15], floor_q88});
				num_q  <= 16'(-{floor_q88[15], floor_q88}) - 16'(att_q);
			end
			ST_MUL: begin
				rem_q <= REM_W'({mul_prod, 1'b0}) + REM_W'(span_q);
			end
			ST_DIV: begin
				// restoring step, one quotient bit a cycle
				if (rem_q >= div_shift) begin
					rem_q        <= rem_q - div_shift;
					quo_q[cnt_q] <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_peak_q  <= p_q;
			out_bar_q   <= quo_q;
			out_color_q <= color_q;
		end
	end

	assign empty      = !out_valid_q;
	assign peak_level = out_peak_q;
	assign bar_pixels = out_bar_q;
	assign bar_color  = out_color_q;

endmodule

// ===== hdl/audio_peak_vu_meter_unit.sv =====
// Audio peak VU meter: takes one stereo frame per clock while full is low and
// tracks the peak magnitude of the selected channel; each frame marked last
// closes a window and queues its peak (four windows deep). The back end, when
// idle, turns each queued peak into a result (log2 lookup, dB scaling, one
// multiply, then a ten-step restoring divider for the bar length); windows
// that end at zero peak, below the floor or at full scale skip the divider.
// Results wait in an output register until popped, and the back end holds its
// next result while that register is occupied. Registers sit at byte addresses
// 0, 4, 8, 12 and 16 of the APB port; the user must write them only while the
// block is idle, as the block itself does not enforce it.
module audio_peak_vu_meter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic [31:0]                   frame_word,
	input  logic                          last_frame,
	input  logic                          pop,
	output logic                          empty,
	output logic [apvu_pkg::PEAK_W-1:0]   peak_level,
	output logic [apvu_pkg::BAR_W-1:0]    bar_pixels,
	output logic [apvu_pkg::COLOR_W-1:0]  bar_color
);

	apvu_pkg::cfg_t              cfg_q;
	logic                        cfg_wr;
	logic [2:0]                  reg_idx;
	logic                        q_full;
	logic                        q_empty;
	logic                        q_push;
	logic                        q_pop;
	logic [apvu_pkg::PEAK_W-1:0] q_wdata;
	logic [apvu_pkg::PEAK_W-1:0] q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_select   <= 1'b0;
			cfg_q.bar_width        <= apvu_pkg::RST_BAR_WIDTH;
			cfg_q.floor_db         <= apvu_pkg::RST_FLOOR_DB;
			cfg_q.yellow_threshold <= apvu_pkg::RST_YELLOW;
			cfg_q.red_threshold    <= apvu_pkg::RST_RED;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				apvu_pkg::REG_CHANNEL_SELECT: cfg_q.channel_select   <= pwdata[0];
				apvu_pkg::REG_BAR_WIDTH:      cfg_q.bar_width        <= pwdata[9:0];
				apvu_pkg::REG_FLOOR_DB:       cfg_q.floor_db         <= pwdata[7:0];
				apvu_pkg::REG_YELLOW_THRESH:  cfg_q.yellow_threshold <= pwdata[14:0];
				apvu_pkg::REG_RED_THRESH:     cfg_q.red_threshold    <= pwdata[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			apvu_pkg::REG_CHANNEL_SELECT: prdata = {31'b0, cfg_q.channel_select};
			apvu_pkg::REG_BAR_WIDTH:      prdata = {22'b0, cfg_q.bar_width};
			apvu_pkg::REG_FLOOR_DB:       prdata = {24'b0, cfg_q.floor_db};
			apvu_pkg::REG_YELLOW_THRESH:  prdata = {17'b0, cfg_q.yellow_threshold};
			apvu_pkg::REG_RED_THRESH:     prdata = {17'b0, cfg_q.red_threshold};
			default:                      prdata = '0;
		endcase
	end

	apvu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.frame_word (frame_word),
		.last_frame (last_frame),
		.push       (push),
		.full       (full),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	apvu_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	apvu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.peak_level (peak_level),
		.bar_pixels (bar_pixels),
		.bar_color  (bar_color)
	);

endmodule

// ===== hdl/apvu_checker.sv =====
// Port-level checker for the VU meter, bound to the top level.
`include "audio_peak_vu_meter_unit_defines.svh"

module apvu_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop,
	input  logic                          empty,
	input  logic [apvu_pkg::PEAK_W-1:0]   peak_level,
	input  logic [apvu_pkg::BAR_W-1:0]    bar_pixels,
	input  logic [apvu_pkg::COLOR_W-1:0]  bar_color
);

	// a waiting result beat holds until popped
	`APVU_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(peak_level) && $stable(bar_pixels) && $stable(bar_color), "result changed while waiting")

	`APVU_ASSERT_NOW(a_color_legal, !empty, bar_color == apvu_pkg::COLOR_GREEN || bar_color == apvu_pkg::COLOR_YELLOW || bar_color == apvu_pkg::COLOR_RED, "illegal bar color")

	// a silent window draws no bar
	`APVU_ASSERT_NOW(a_silent_bar, !empty && peak_level == '0, bar_pixels == '0, "bar drawn for zero peak")

endmodule

bind audio_peak_vu_meter_unit apvu_checker u_apvu_checker (.*);
